### sv/bvsg_pkg.sv
package bvsg_pkg;

    // Fixed formats
    localparam int CURVE_POINTS     = 11;
    localparam int FILTER_FRAC_BITS = 16;
    localparam int TAP_W            = 13;
    localparam int MV_W             = 16;
    localparam int FILT_W           = MV_W + FILTER_FRAC_BITS;
    localparam int DIV_GAIN_W       = 16;
    localparam int SMOOTH_GAIN_W    = 17;
    localparam int PROD_W           = FILT_W + SMOOTH_GAIN_W;
    localparam int PCT_W            = 7;
    localparam int IDX_W            = $clog2(CURVE_POINTS);
    localparam int SEG_W            = $clog2(CURVE_POINTS - 1);
    // Widest curve segment is 300 mV, steepest rise 15 percent
    localparam int DV_W             = 9;
    localparam int QUO_W            = 4;
    localparam int SHAMT_W          = $clog2(QUO_W);
    localparam int NUM_W            = 11;
    localparam int STEP_W           = 4;

    typedef logic [MV_W-1:0]  mv_t;
    typedef logic [PCT_W-1:0] pct_t;
    typedef logic [STEP_W-1:0] step_t;

    // LiPo discharge curve, highest point first
    localparam mv_t CURVE_MV [CURVE_POINTS] = '{
        16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700,
        16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3000
    };
    localparam pct_t CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd65, 7'd50, 7'd35,
        7'd20,  7'd12, 7'd8,  7'd5,  7'd0
    };

    // Register reset values and tier limits
    localparam logic [DIV_GAIN_W-1:0]    DIV_GAIN_RESET    = 16'd8192;
    localparam logic [SMOOTH_GAIN_W-1:0] SMOOTH_GAIN_RESET = 17'd13107;
    localparam logic [SMOOTH_GAIN_W-1:0] ALPHA_ONE         = 17'h10000;
    localparam pct_t HEALTHY_ABOVE = 7'd50;
    localparam pct_t LOW_FROM      = 7'd20;

    typedef enum logic [0:0] {
        REG_DIVIDER_GAIN   = 1'b0,
        REG_SMOOTHING_GAIN = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TIER_HEALTHY  = 2'd0,
        TIER_LOW      = 2'd1,
        TIER_CRITICAL = 2'd2
    } tier_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_TAP,
        OP_SCALE,
        OP_SEED,
        OP_MUL_ALPHA,
        OP_UPDATE,
        OP_ROUND,
        OP_CLASSIFY,
        OP_INTERP,
        OP_DIV,
        OP_PCT,
        OP_EMIT
    } op_t;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        CND_NEXT,
        CND_IF_CLEAR,
        CND_IF_FIRST,
        CND_IF_EDGE,
        CND_WAIT_IN,
        CND_WAIT_OUT
    } cond_t;

    // Program labels
    localparam step_t STEP_FETCH = 4'd0;
    localparam step_t STEP_ROUND = 4'd6;
    localparam step_t STEP_EMIT  = 4'd14;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        step_t              target;
        logic [SHAMT_W-1:0] shamt;
    } uword_t;

    typedef struct packed {
        logic is_clear;
        logic has_sample;
        logic edge_hit;
    } dp_stat_t;

    typedef struct packed {
        mv_t   voltage;
        pct_t  percent;
        tier_t tier;
        logic  valid;
    } result_t;

endpackage

### sv/bvsg_ucode_rom.sv
module bvsg_ucode_rom
    import bvsg_pkg::*;
(
    input  step_t  step,
    output uword_t uword
);

    // Control store: one word per step
    always_comb begin
        unique case (step)
            4'd0:  uword = '{op: OP_LOAD,      cond: CND_WAIT_IN,  target: STEP_FETCH, shamt: 2'd0};
            4'd1:  uword = '{op: OP_MUL_TAP,   cond: CND_IF_CLEAR, target: STEP_ROUND, shamt: 2'd0};
            4'd2:  uword = '{op: OP_SCALE,     cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd3:  uword = '{op: OP_SEED,      cond: CND_IF_FIRST, target: STEP_ROUND, shamt: 2'd0};
            4'd4:  uword = '{op: OP_MUL_ALPHA, cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd5:  uword = '{op: OP_UPDATE,    cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd6:  uword = '{op: OP_ROUND,     cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd7:  uword = '{op: OP_CLASSIFY,  cond: CND_IF_EDGE,  target: STEP_EMIT,  shamt: 2'd0};
            4'd8:  uword = '{op: OP_INTERP,    cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd9:  uword = '{op: OP_DIV,       cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd3};
            4'd10: uword = '{op: OP_DIV,       cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd2};
            4'd11: uword = '{op: OP_DIV,       cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd1};
            4'd12: uword = '{op: OP_DIV,       cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd13: uword = '{op: OP_PCT,       cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
            4'd14: uword = '{op: OP_EMIT,      cond: CND_WAIT_OUT, target: STEP_FETCH, shamt: 2'd0};
            default: uword = '{op: OP_NOP,     cond: CND_NEXT,     target: STEP_FETCH, shamt: 2'd0};
        endcase
    end

endmodule

### sv/bvsg_datapath.sv
module bvsg_datapath
    import bvsg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  uword_t                   uword,
    input  logic                     exec,
    input  logic                     in_opcode,
    input  logic [TAP_W-1:0]         in_tap,
    input  logic [DIV_GAIN_W-1:0]    divider_gain,
    input  logic [SMOOTH_GAIN_W-1:0] smoothing_gain,
    output dp_stat_t                 stat,
    output result_t                  result
);

    // State
    logic              has_reg, has_next;
    logic [FILT_W-1:0] filt_reg, filt_next;

    // Working registers
    logic              opc_reg, opc_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    mv_t               scaled_reg, scaled_next;
    logic [FILT_W-1:0] mag_reg, mag_next;
    logic              neg_reg, neg_next;
    mv_t               mv_reg, mv_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    pct_t              pct_reg, pct_next;

    logic [TAP_W-2:0]         tap_clamp;
    logic [27:0]              tap_prod;
    logic [28:0]              scale_sum;
    mv_t                      scaled_w;
    logic [FILT_W-1:0]        target;
    logic [SMOOTH_GAIN_W-1:0] alpha;
    logic [PROD_W:0]          step_sum;
    logic [FILT_W-1:0]        step_w;
    logic [FILT_W:0]          round_sum;
    mv_t                      mv_w;
    logic [SEG_W-1:0]         seg_w;
    logic [IDX_W-1:0]         hi_idx, lo_idx;
    mv_t                      lo_mv;
    pct_t                     lo_pct;
    logic [DV_W-1:0]          dv, off;
    logic [QUO_W-1:0]         dp;
    logic [QUO_W+DV_W-1:0]    num_w;
    logic [NUM_W:0]           dvs;
    logic                     at_top, at_bottom;
    tier_t                    tier_w;

    // Scaling and filter arithmetic
    always_comb begin
        tap_clamp = tap_reg[TAP_W-1] ? '0 : tap_reg[TAP_W-2:0];
        tap_prod  = tap_clamp * divider_gain;
        scale_sum = prod_reg[27:0] + 29'd2048;
        scaled_w  = scale_sum[28] ? '1 : scale_sum[27:12];
        target    = {scaled_reg, {FILTER_FRAC_BITS{1'b0}}};
        alpha     = (smoothing_gain > ALPHA_ONE) ? ALPHA_ONE : smoothing_gain;
        step_sum  = {1'b0, prod_reg} + (PROD_W+1)'(32768);
        step_w    = step_sum[FILT_W+15:16];
        round_sum = {1'b0, filt_reg} + (FILT_W+1)'(1 << (FILTER_FRAC_BITS - 1));
        if (!has_reg) begin
            mv_w = '0;
        end else if (round_sum[FILT_W]) begin
            mv_w = '1;
        end else begin
            mv_w = round_sum[FILT_W-1:FILTER_FRAC_BITS];
        end
    end

    // Curve segment lookup and interpolation terms
    always_comb begin
        seg_w = '0;
        for (int j = 1; j < CURVE_POINTS; j++) begin
            if (CURVE_MV[j] > mv_reg) seg_w = seg_w + 1'b1;
        end
        at_top    = (mv_reg >= CURVE_MV[0]);
        at_bottom = (mv_reg <= CURVE_MV[CURVE_POINTS-1]);
        hi_idx    = IDX_W'(seg_reg);
        lo_idx    = hi_idx + 1'b1;
        lo_mv     = CURVE_MV[lo_idx];
        lo_pct    = CURVE_PCT[lo_idx];
        dv        = DV_W'(CURVE_MV[hi_idx] - lo_mv);
        dp        = QUO_W'(CURVE_PCT[hi_idx] - lo_pct);
        off       = DV_W'(mv_reg - lo_mv);
        num_w     = dp * off + (QUO_W+DV_W)'(dv >> 1);
        dvs       = (NUM_W+1)'({3'b000, dv} << uword.shamt);
        if (pct_reg > HEALTHY_ABOVE) begin
            tier_w = TIER_HEALTHY;
        end else if (pct_reg >= LOW_FROM) begin
            tier_w = TIER_LOW;
        end else begin
            tier_w = TIER_CRITICAL;
        end
    end

    // Operation decode
    always_comb begin
        has_next    = has_reg;
        filt_next   = filt_reg;
        opc_next    = opc_reg;
        tap_next    = tap_reg;
        prod_next   = prod_reg;
        scaled_next = scaled_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        mv_next     = mv_reg;
        seg_next    = seg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        pct_next    = pct_reg;
        if (exec) begin
            unique case (uword.op)
                OP_LOAD: begin
                    opc_next = in_opcode;
                    tap_next = in_tap;
                end
                OP_MUL_TAP: begin
                    prod_next = PROD_W'(tap_prod);
                    if (opc_reg) begin
                        filt_next = '0;
                        has_next  = 1'b0;
                    end
                end
                OP_SCALE: scaled_next = scaled_w;
                OP_SEED: begin
                    if (!has_reg) begin
                        filt_next = target;
                        has_next  = 1'b1;
                    end else begin
                        neg_next = (target < filt_reg);
                        mag_next = (target < filt_reg) ? filt_reg - target : target - filt_reg;
                    end
                end
                OP_MUL_ALPHA: prod_next = mag_reg * alpha;
                OP_UPDATE: filt_next = neg_reg ? filt_reg - step_w : filt_reg + step_w;
                OP_ROUND: mv_next = mv_w;
                OP_CLASSIFY: begin
                    seg_next = seg_w;
                    if (at_top) begin
                        pct_next = CURVE_PCT[0];
                    end else if (at_bottom) begin
                        pct_next = CURVE_PCT[CURVE_POINTS-1];
                    end
                end
                OP_INTERP: begin
                    rem_next = NUM_W'(num_w);
                    quo_next = '0;
                end
                OP_DIV: begin
                    if ({1'b0, rem_reg} >= dvs) begin
                        rem_next = rem_reg - dvs[NUM_W-1:0];
                        quo_next[uword.shamt] = 1'b1;
                    end
                end
                OP_PCT: pct_next = lo_pct + PCT_W'(quo_reg);
                default: ;
            endcase
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_reg  <= 1'b0;
            filt_reg <= '0;
        end else begin
            has_reg  <= has_next;
            filt_reg <= filt_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        opc_reg    <= opc_next;
        tap_reg    <= tap_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        mv_reg     <= mv_next;
        seg_reg    <= seg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        pct_reg    <= pct_next;
    end

    assign stat.is_clear   = opc_reg;
    assign stat.has_sample = has_reg;
    assign stat.edge_hit   = at_top | at_bottom;

    assign result.voltage = mv_reg;
    assign result.percent = pct_reg;
    assign result.tier    = tier_w;
    assign result.valid   = has_reg;

endmodule

### sv/battery_voltage_smoother_gauge.sv
// Each item is accepted and carried to a result by the microcode program that steps
// one shared datapath through scaling, filter update and interpolation; the seeding
// sample, a voltage that lies off the curve and a clear take shorter paths. A new item
// is accepted only once the previous result has been handed to the output register.
// Reset (aresetn low, synchronous) empties the filter, clears validity, drops
// m_tvalid and returns both gain registers to their defaults.
module battery_voltage_smoother_gauge
    import bvsg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [12:0] tap_voltage
    input  logic                     s_tuser,   // [0] opcode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,   // [15:0] battery_voltage, [22:16] charge_percent,
                                                // [24:23] charge_tier
    output logic                     m_tuser,   // [0] reading_valid
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [SMOOTH_GAIN_W-1:0] cfg_wdata
);

    logic [DIV_GAIN_W-1:0]    divider_gain_reg;
    logic [SMOOTH_GAIN_W-1:0] smoothing_gain_reg;
    step_t                    pc_reg, pc_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [31:0]              m_tdata_reg;
    logic                     m_tuser_reg;
    uword_t                   uword;
    dp_stat_t                 dp_stat;
    result_t                  result;
    logic                     exec;
    logic                     out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_gain_reg   <= DIV_GAIN_RESET;
            smoothing_gain_reg <= SMOOTH_GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_DIVIDER_GAIN:   divider_gain_reg   <= cfg_wdata[DIV_GAIN_W-1:0];
                REG_SMOOTHING_GAIN: smoothing_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bvsg_ucode_rom u_rom (
        .step  (pc_reg),
        .uword (uword)
    );

    bvsg_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .uword          (uword),
        .exec           (exec),
        .in_opcode      (s_tuser),
        .in_tap         (s_tdata[TAP_W-1:0]),
        .divider_gain   (divider_gain_reg),
        .smoothing_gain (smoothing_gain_reg),
        .stat           (dp_stat),
        .result         (result)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: step counter with conditional jumps and wait states
    always_comb begin
        exec    = 1'b1;
        pc_next = pc_reg + 1'b1;
        unique case (uword.cond)
            CND_NEXT:     pc_next = pc_reg + 1'b1;
            CND_IF_CLEAR: if (dp_stat.is_clear) pc_next = uword.target;
            CND_IF_FIRST: if (!dp_stat.has_sample) pc_next = uword.target;
            CND_IF_EDGE:  if (dp_stat.edge_hit) pc_next = uword.target;
            CND_WAIT_IN: begin
                exec    = s_tvalid;
                pc_next = s_tvalid ? pc_reg + 1'b1 : pc_reg;
            end
            CND_WAIT_OUT: begin
                exec    = out_free;
                pc_next = out_free ? uword.target : pc_reg;
            end
            default: pc_next = STEP_FETCH;
        endcase
    end

    assign s_tready = (uword.cond == CND_WAIT_IN);

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (exec && uword.op == OP_EMIT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_FETCH;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && uword.op == OP_EMIT) begin
            m_tdata_reg <= {7'd0, result.tier, result.percent, result.voltage};
            m_tuser_reg <= result.valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // One item in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // A clear empties the filter at its MUL_TAP step
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |-> ##2 !dp_stat.has_sample)
        else $error("clear did not reset filter validity");

    // No reading means zero voltage and percent
    a_no_reading_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[22:0] == 23'd0))
        else $error("nonzero voltage or percent without a reading");

    // Percent stays on the curve range
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] <= 7'd100))
        else $error("charge percent above 100");

endmodule
